/* rtl/can_alias_reservation_defines.svh */
// Assertion macros for the alias reservation block.
// Each expects a clock named clock and a synchronous reset named reset in scope.
`ifndef CAN_ALIAS_RESERVATION_DEFINES_SVH
`define CAN_ALIAS_RESERVATION_DEFINES_SVH

`ifndef SYNTHESIS
`define CAR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CAR_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define CAR_ASSERT(label, prop, msg)
`define CAR_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

/* rtl/car_pkg.sv */
`default_nettype none

package car_pkg;

   localparam int WAIT_COUNT_BITS = 16;
   localparam int WAIT_TICKS_BITS = 16;
   localparam int NODE_ID_BITS    = 48;
   localparam int ALIAS_BITS      = 12;

   localparam logic [2:0]                 CID_FIRST       = 3'd7;
   localparam logic [2:0]                 CID_LAST        = 3'd4;
   localparam logic [WAIT_TICKS_BITS-1:0] WAIT_TICKS_RESET = 16'd200;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_SLOT  = 2'd1,
      OP_FRAME = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      EV_CID     = 2'd0,
      EV_RID     = 2'd1,
      EV_ABANDON = 2'd2
   } event_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_SEND = 2'd1,
      PH_WAIT = 2'd2,
      PH_RID  = 2'd3
   } phase_type;

   typedef enum logic [0:0] {
      CSR_NODE_ID    = 1'b0,
      CSR_WAIT_TICKS = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type                 operation;
      logic [ALIAS_BITS-1:0]  seen_alias;
   } req_type;

   typedef struct packed {
      event_kind_type         event_kind;
      logic [ALIAS_BITS-1:0]  alias_res;
      logic [2:0]             cid_sequence;
      logic [ALIAS_BITS-1:0]  id_chunk;
   } rsp_type;

   typedef struct packed {
      logic [ALIAS_BITS-1:0]  pending;
      logic [ALIAS_BITS-1:0]  next_seed;
   } draw_type;

   function automatic logic [ALIAS_BITS-1:0] seed_from_id(input logic [NODE_ID_BITS-1:0] id);
      return id[41:30] ^ id[29:18] ^ id[17:6] ^ {6'd0, id[47:42]} ^ {id[5:0], 6'd0};
   endfunction

   // always odd, so a zero draw is followed by a nonzero one
   function automatic logic [ALIAS_BITS-1:0] seed_offset(input logic [NODE_ID_BITS-1:0] id);
      logic [ALIAS_BITS-1:0] fold;
      fold = id[47:36] ^ id[35:24] ^ id[23:12] ^ id[11:0];
      return {fold[ALIAS_BITS-2:0], 1'b1};
   endfunction

   function automatic logic [WAIT_COUNT_BITS-1:0] sat_wait(
      input logic [WAIT_TICKS_BITS-1:0] ticks
   );
      logic [WAIT_TICKS_BITS-1:0] upper;
      upper = ticks >> WAIT_COUNT_BITS;
      if (upper != '0) begin
         return '1;
      end
      return WAIT_COUNT_BITS'(ticks);
   endfunction

endpackage

`default_nettype wire

/* rtl/can_alias_reservation.sv */
// CAN alias reservation.
// Input channel (req_valid / req_stall / req_data): one transaction per event:
// start, transmit slot granted, frame seen (with its source alias) or timer tick.
// Result channel (rsp_valid / rsp_stall / rsp_data): CID frame sent, RID frame
// sent (alias reserved) or alias abandoned; most events produce no result.
// Configuration (csr_we / csr_index / csr_wdata): node ID and wait length, to be
// written only while no transaction is in flight; the block does not enforce it.
// An accepted transaction waits in the input register until the result register
// is free. One transaction is taken every cycle while req_stall is low; each
// event's state update is a single pass between the input and result registers.
// Reset clears both pipeline registers, returns to idle, sets node ID 0 and a
// wait of 200 ticks. While rsp_stall holds a pending result, req_stall rises as
// soon as the input register is full; nothing is dropped.
`default_nettype none

`include "can_alias_reservation_defines.svh"

module can_alias_reservation
   import car_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  csr_index_type          csr_index,
   input  logic [NODE_ID_BITS-1:0] csr_wdata
);

   logic                       in_valid_ff, in_valid_in;
   req_type                    in_data_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff;

   phase_type                  phase_ff, phase_in;
   logic [NODE_ID_BITS-1:0]    node_id_ff, node_id_in;
   logic [WAIT_TICKS_BITS-1:0] wait_ticks_ff, wait_ticks_in;
   logic [ALIAS_BITS-1:0]      seed_ff, seed_in;
   logic [ALIAS_BITS-1:0]      pending_ff, pending_in;
   logic [2:0]                 cid_count_ff, cid_count_in;
   logic                       conflict_ff, conflict_in;
   logic [WAIT_COUNT_BITS-1:0] wait_count_ff, wait_count_in;

   logic                       out_free;
   logic                       advance;
   logic                       req_accept;
   logic                       res_valid;
   rsp_type                    res;
   logic [2:0]                 seq;
   logic [ALIAS_BITS-1:0]      chunk;
   draw_type                   draw;

   car_alias_gen u_alias_gen (
      .node_id (node_id_ff),
      .seed    (seed_ff),
      .draw    (draw)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign seq = cid_count_ff[2] ? cid_count_ff : CID_LAST;

   always_comb begin
      unique case (seq[1:0])
         2'd3:    chunk = node_id_ff[47:36];
         2'd2:    chunk = node_id_ff[35:24];
         2'd1:    chunk = node_id_ff[23:12];
         default: chunk = node_id_ff[11:0];
      endcase
   end

   // event processing and phase control
   always_comb begin
      phase_in      = phase_ff;
      seed_in       = seed_ff;
      pending_in    = pending_ff;
      cid_count_in  = cid_count_ff;
      conflict_in   = conflict_ff;
      wait_count_in = wait_count_ff;
      res_valid     = 1'b0;
      res           = '{event_kind: EV_ABANDON, alias_res: pending_ff,
                        cid_sequence: 3'd0, id_chunk: '0};

      if (advance) begin
         unique case (in_data_ff.operation)
            OP_START: begin
               if (phase_ff == PH_IDLE) begin
                  phase_in     = PH_SEND;
                  seed_in      = draw.next_seed;
                  pending_in   = draw.pending;
                  cid_count_in = CID_FIRST;
                  conflict_in  = 1'b0;
               end
            end
            OP_SLOT: begin
               if (phase_ff == PH_SEND) begin
                  res_valid = 1'b1;
                  if (conflict_ff) begin
                     // slot spent announcing the abandon; redraw at once
                     seed_in      = draw.next_seed;
                     pending_in   = draw.pending;
                     cid_count_in = CID_FIRST;
                     conflict_in  = 1'b0;
                  end else begin
                     res.event_kind   = EV_CID;
                     res.cid_sequence = seq;
                     res.id_chunk     = chunk;
                     cid_count_in     = seq - 3'd1;
                     if (seq == CID_LAST) begin
                        wait_count_in = sat_wait(wait_ticks_ff);
                        phase_in      = PH_WAIT;
                     end
                  end
               end else if (phase_ff == PH_RID) begin
                  res_valid      = 1'b1;
                  res.event_kind = EV_RID;
                  pending_in     = '0;
                  phase_in       = PH_IDLE;
               end
            end
            OP_FRAME: begin
               if ((phase_ff == PH_SEND || phase_ff == PH_WAIT) &&
                   in_data_ff.seen_alias == pending_ff) begin
                  conflict_in = 1'b1;
               end
            end
            OP_TICK: begin
               if (phase_ff == PH_WAIT) begin
                  if (wait_count_ff <= WAIT_COUNT_BITS'(1)) begin
                     wait_count_in = '0;
                     if (conflict_ff) begin
                        res_valid    = 1'b1;
                        phase_in     = PH_SEND;
                        seed_in      = draw.next_seed;
                        pending_in   = draw.pending;
                        cid_count_in = CID_FIRST;
                        conflict_in  = 1'b0;
                     end else begin
                        phase_in = PH_RID;
                     end
                  end else begin
                     wait_count_in = wait_count_ff - WAIT_COUNT_BITS'(1);
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // a node ID write re-seeds immediately
      node_id_in    = node_id_ff;
      wait_ticks_in = wait_ticks_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NODE_ID: begin
               node_id_in = csr_wdata;
               seed_in    = seed_from_id(csr_wdata);
            end
            CSR_WAIT_TICKS: begin
               wait_ticks_in = csr_wdata[WAIT_TICKS_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      in_valid_in  = req_accept || (in_valid_ff && !out_free);
      rsp_valid_in = out_free ? (advance && res_valid) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         node_id_ff    <= '0;
         wait_ticks_ff <= WAIT_TICKS_RESET;
         seed_ff       <= seed_from_id('0);
         pending_ff    <= '0;
         cid_count_ff  <= CID_FIRST;
         conflict_ff   <= 1'b0;
         wait_count_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         node_id_ff    <= node_id_in;
         wait_ticks_ff <= wait_ticks_in;
         seed_ff       <= seed_in;
         pending_ff    <= pending_in;
         cid_count_ff  <= cid_count_in;
         conflict_ff   <= conflict_in;
         wait_count_ff <= wait_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   `CAR_ASSERT(a_pending_nonzero, (phase_ff != PH_IDLE) |-> (pending_ff != '0), "busy with alias zero")
   `CAR_ASSERT(a_rsp_alias_nonzero, rsp_valid_ff |-> (rsp_data_ff.alias_res != '0), "result alias zero")
   `CAR_ASSERT(a_cid_seq_range, (rsp_valid_ff && rsp_data_ff.event_kind == EV_CID) |-> rsp_data_ff.cid_sequence[2], "CID number out of range")
   `CAR_ASSERT_NEXT(a_in_hold, in_valid_ff && !out_free, in_valid_ff && $stable(in_data_ff), "held transaction lost")
   `CAR_ASSERT_NEXT(a_wait_loaded, advance && phase_ff == PH_SEND && phase_in == PH_WAIT, phase_ff == PH_WAIT && cid_count_ff == 3'd3, "wait not armed")

endmodule

`default_nettype wire

/* rtl/car_alias_gen.sv */
`default_nettype none

module car_alias_gen
   import car_pkg::*;
(
   input  logic [NODE_ID_BITS-1:0] node_id,
   input  logic [ALIAS_BITS-1:0]   seed,
   output draw_type                draw
);

   logic [ALIAS_BITS-1:0] offset;
   logic [ALIAS_BITS-1:0] step1;
   logic [ALIAS_BITS-1:0] step2;

   assign offset = seed_offset(node_id);
   assign step1  = seed + offset;
   assign step2  = step1 + offset;

   // alias zero is never handed out: take the following value instead
   always_comb begin
      if (seed == '0) begin
         draw.pending   = step1;
         draw.next_seed = step2;
      end else begin
         draw.pending   = seed;
         draw.next_seed = step1;
      end
   end

endmodule

`default_nettype wire
